/* rtl/card_detect_mount_fsm_defines.svh */
// Assertion macros for the card detect mount block.
`ifndef CARD_DETECT_MOUNT_FSM_DEFINES_SVH
`define CARD_DETECT_MOUNT_FSM_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CDM_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define CDM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/cdm_pkg.sv */
`timescale 1ns / 1ps

package cdm_pkg;

  localparam int unsigned CDM_TIMER_BITS = 16;
  localparam int unsigned CDM_CFG_W      = 16;
  localparam logic [CDM_CFG_W-1:0] CDM_DEBOUNCE_RESET = 16'd500;

  // State codes as reported on the result channel
  localparam logic [2:0] ST_START     = 3'd0;
  localparam logic [2:0] ST_MOUNTED   = 3'd1;
  localparam logic [2:0] ST_FAILED    = 3'd2;
  localparam logic [2:0] ST_UNMOUNTED = 3'd3;
  localparam logic [2:0] ST_DEBOUNCE  = 3'd4;

  // Error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_MISSING = 2'd1;
  localparam logic [1:0] ERR_MOUNT   = 2'd2;

  typedef struct packed {
    logic card_present;
    logic time_tick;
    logic mount_ok;
  } cdm_req_t;

  typedef struct packed {
    logic [2:0] fsm_state;
    logic       mounted;
    logic       mount_attempt;
    logic       unmount_request;
    logic       state_changed;
    logic [1:0] error_code;
  } cdm_rsp_t;

endpackage

/* rtl/card_detect_mount_fsm.sv */
`timescale 1ns / 1ps
// Channel   | Signals                         | Direction | Payload
// ----------+---------------------------------+-----------+-----------------------
// request   | req_valid, req_ready, req       | in        | cdm_req_t (3 bits)
// result    | rsp_valid, rsp_ready, rsp       | out       | cdm_rsp_t (9 bits)
// config    | cfg_we, cfg_data                | in        | debounce_ms, 16 bits
//
// One request per cycle unless a held result stalls it: the state update and the
// result are computed when a request is accepted; the result shows next cycle.
// The result register holds one entry; a new request is taken whenever that
// entry is empty or is being taken in the same cycle.
// Reset (rst, synchronous) returns to the start state, disarms the debounce
// timer, clears the last error and loads 500 into debounce_ms.
module card_detect_mount_fsm import cdm_pkg::*; #(
  parameter int unsigned TIMER_BITS = CDM_TIMER_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  cdm_req_t             req,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output cdm_rsp_t             rsp,
  input  logic                 cfg_we,
  input  logic [CDM_CFG_W-1:0] cfg_data
);

  logic [CDM_CFG_W-1:0] debounce_ms;
  logic                 step;
  cdm_rsp_t             rsp_next;

  // Take a request when the result slot is free or draining this cycle
  assign req_ready = !rsp_valid || rsp_ready;
  assign step      = req_valid && req_ready;

  // Debounce length register; the user must write it only while the block is idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms <= CDM_DEBOUNCE_RESET;
    end else if (cfg_we) begin
      debounce_ms <= cfg_data;
    end
  end

  // State machine plus debounce timer; advances once per accepted request
  cdm_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .req         (req),
    .debounce_ms (debounce_ms),
    .rsp_next    (rsp_next)
  );

  // Result register: hold until taken, load on every accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (step) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      rsp <= rsp_next;
    end
  end

endmodule

/* rtl/cdm_core.sv */
`timescale 1ns / 1ps

module cdm_core import cdm_pkg::*; #(
  parameter int unsigned TIMER_BITS = CDM_TIMER_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  cdm_req_t             req,
  input  logic [CDM_CFG_W-1:0] debounce_ms,
  output cdm_rsp_t             rsp_next
);

  typedef enum logic [2:0] {
    S_START     = ST_START,
    S_MOUNTED   = ST_MOUNTED,
    S_FAILED    = ST_FAILED,
    S_UNMOUNTED = ST_UNMOUNTED,
    S_DEBOUNCE  = ST_DEBOUNCE
  } state_t;

  localparam logic [32:0] TMAX = 33'({TIMER_BITS{1'b1}});

  state_t                state, state_next, state_mid;
  logic [TIMER_BITS-1:0] remaining, remaining_next, remaining_mid, load;
  logic                  armed, armed_next, armed_mid;
  logic [1:0]            last_error, last_error_next, last_error_mid;
  logic                  just_armed, attempt, unmount_req;

  // Clamp the configured debounce to what the timer can hold
  always_comb begin
    if (33'(debounce_ms) > TMAX) begin
      load = '1;
    end else begin
      load = TIMER_BITS'(debounce_ms);
    end
  end

  always_comb begin
    state_mid      = state;
    remaining_mid  = remaining;
    armed_mid      = armed;
    last_error_mid = last_error;
    just_armed     = 1'b0;
    attempt        = 1'b0;
    unmount_req    = 1'b0;

    // Presence event first
    unique case (state)
      S_START: begin
        if (req.card_present) begin
          attempt        = 1'b1;
          state_mid      = req.mount_ok ? S_MOUNTED : S_FAILED;
          last_error_mid = req.mount_ok ? ERR_NONE : ERR_MOUNT;
        end else begin
          state_mid = S_UNMOUNTED;
        end
      end
      S_MOUNTED: begin
        if (!req.card_present) begin
          unmount_req    = 1'b1;
          last_error_mid = ERR_MISSING;
          state_mid      = S_UNMOUNTED;
        end
      end
      S_FAILED: begin
        if (!req.card_present) begin
          state_mid = S_UNMOUNTED;
        end
      end
      S_UNMOUNTED: begin
        if (req.card_present) begin
          state_mid     = S_DEBOUNCE;
          remaining_mid = load;
          armed_mid     = 1'b1;
          just_armed    = 1'b1;
        end
      end
      S_DEBOUNCE: begin
        if (!req.card_present) begin
          state_mid     = S_UNMOUNTED;
          armed_mid     = 1'b0;
          remaining_mid = '0;
        end
      end
      default: state_mid = S_START;
    endcase

    state_next      = state_mid;
    remaining_next  = remaining_mid;
    armed_next      = armed_mid;
    last_error_next = last_error_mid;

    // Then the timer, on ticks only; the arming tick does not count
    if (req.time_tick && armed_mid && !just_armed) begin
      if (remaining_mid != '0) begin
        remaining_next = remaining_mid - 1'b1;
      end
      if (remaining_next == '0) begin
        armed_next = 1'b0;
        if (state_mid == S_DEBOUNCE) begin
          attempt         = 1'b1;
          state_next      = req.mount_ok ? S_MOUNTED : S_FAILED;
          last_error_next = req.mount_ok ? ERR_NONE : ERR_MOUNT;
        end
      end
    end

    rsp_next.fsm_state       = state_next;
    rsp_next.mounted         = (state_next == S_MOUNTED);
    rsp_next.mount_attempt   = attempt;
    rsp_next.unmount_request = unmount_req;
    rsp_next.state_changed   = (state_next != state);
    rsp_next.error_code      = last_error_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_START;
      remaining  <= '0;
      armed      <= 1'b0;
      last_error <= ERR_NONE;
    end else if (step) begin
      state      <= state_next;
      remaining  <= remaining_next;
      armed      <= armed_next;
      last_error <= last_error_next;
    end
  end

endmodule

/* rtl/cdm_checker.sv */
`timescale 1ns / 1ps
`include "card_detect_mount_fsm_defines.svh"

module cdm_checker import cdm_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     req_valid,
  input logic     req_ready,
  input logic     rsp_valid,
  input cdm_rsp_t rsp
);

  `CDM_ASSERT_NEXT(a_req_gives_rsp, clk, rst, req_valid && req_ready, rsp_valid, "accepted request produced no result")

  `CDM_ASSERT_NOW(a_mounted_flag, clk, rst, rsp_valid, rsp.mounted == (rsp.fsm_state == ST_MOUNTED), "mounted flag disagrees with state")

  `CDM_ASSERT_NOW(a_attempt_outcome, clk, rst, rsp_valid && rsp.mount_attempt, (rsp.fsm_state == ST_MOUNTED && rsp.error_code == ERR_NONE) || (rsp.fsm_state == ST_FAILED && rsp.error_code == ERR_MOUNT), "mount attempt with wrong outcome")

  `CDM_ASSERT_NOW(a_unmount, clk, rst, rsp_valid && rsp.unmount_request, rsp.fsm_state == ST_UNMOUNTED && rsp.error_code == ERR_MISSING && rsp.state_changed, "unmount request without removal")

endmodule

bind card_detect_mount_fsm cdm_checker u_cdm_checker (.*);

/* tb/card_detect_mount_checker.sv */
`timescale 1ns / 1ps

module card_detect_mount_checker import cdm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  logic                 req_ready,
  input  cdm_req_t             req,
  input  logic                 rsp_valid,
  input  logic                 rsp_ready,
  input  cdm_rsp_t             rsp,
  input  logic                 cfg_we,
  input  logic [CDM_CFG_W-1:0] cfg_data,
  output int                   fail_count,
  output int                   pending,
  output int                   results_seen,
  output int                   attempts_seen,
  output int                   unmounts_seen
);

  // Shadow of the block's state and its one register
  logic [2:0]                st_m;
  logic [CDM_TIMER_BITS-1:0] remain_m;
  logic                      armed_m;
  logic [1:0]                err_m;
  logic [CDM_CFG_W-1:0]      deb_m;

  cdm_rsp_t status_q[$];

  initial begin
    fail_count    = 0;
    pending       = 0;
    results_seen  = 0;
    attempts_seen = 0;
    unmounts_seen = 0;
  end

  task automatic report_mismatch(input string msg);
    if (fail_count < 40) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
    fail_count++;
  endtask

  function automatic logic [2:0] mount_outcome(input logic ok);
    if (ok) begin
      err_m = ERR_NONE;
      return ST_MOUNTED;
    end
    err_m = ERR_MOUNT;
    return ST_FAILED;
  endfunction

  // Advance the shadow state by one request and return the status it yields
  function automatic cdm_rsp_t mount_fsm_step(input cdm_req_t r);
    cdm_rsp_t   o;
    logic [2:0] prior;
    logic       tried;
    logic       unmnt;
    logic       armed_now;
    prior     = st_m;
    tried     = 1'b0;
    unmnt     = 1'b0;
    armed_now = 1'b0;
    case (st_m)
      ST_START: begin
        if (r.card_present) begin
          tried = 1'b1;
          st_m  = mount_outcome(r.mount_ok);
        end else begin
          st_m = ST_UNMOUNTED;
        end
      end
      ST_MOUNTED: begin
        if (!r.card_present) begin
          unmnt = 1'b1;
          err_m = ERR_MISSING;
          st_m  = ST_UNMOUNTED;
        end
      end
      ST_FAILED: begin
        if (!r.card_present) st_m = ST_UNMOUNTED;
      end
      ST_UNMOUNTED: begin
        if (r.card_present) begin
          st_m      = ST_DEBOUNCE;
          remain_m  = deb_m;
          armed_m   = 1'b1;
          armed_now = 1'b1;
        end
      end
      ST_DEBOUNCE: begin
        if (!r.card_present) begin
          st_m     = ST_UNMOUNTED;
          armed_m  = 1'b0;
          remain_m = '0;
        end
      end
      default: st_m = ST_START;
    endcase
    // Tick of the arming step does not count; counter saturates at zero
    if (r.time_tick && armed_m && !armed_now) begin
      if (remain_m != '0) remain_m = remain_m - 1'b1;
      if (remain_m == '0) begin
        armed_m = 1'b0;
        if (st_m == ST_DEBOUNCE) begin
          tried = 1'b1;
          st_m  = mount_outcome(r.mount_ok);
        end
      end
    end
    o.fsm_state       = st_m;
    o.mounted         = (st_m == ST_MOUNTED);
    o.mount_attempt   = tried;
    o.unmount_request = unmnt;
    o.state_changed   = (st_m != prior);
    o.error_code      = err_m;
    return o;
  endfunction

  always @(posedge clk) begin
    cdm_rsp_t want;
    if (rst) begin
      st_m     = ST_START;
      remain_m = '0;
      armed_m  = 1'b0;
      err_m    = ERR_NONE;
      deb_m    = CDM_DEBOUNCE_RESET;
      status_q.delete();
    end else begin
      if (cfg_we) deb_m = cfg_data;
      if (rsp_valid && rsp_ready) begin
        results_seen++;
        if (status_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: %b", rsp));
        end else begin
          want = status_q.pop_front();
          if (want.mount_attempt) attempts_seen++;
          if (want.unmount_request) unmounts_seen++;
          if (rsp.fsm_state !== want.fsm_state)
            report_mismatch($sformatf("fsm_state %0d, expected %0d",
                                      rsp.fsm_state, want.fsm_state));
          if (rsp.mounted !== want.mounted)
            report_mismatch($sformatf("mounted %b, expected %b",
                                      rsp.mounted, want.mounted));
          if (rsp.mount_attempt !== want.mount_attempt)
            report_mismatch($sformatf("mount_attempt %b, expected %b",
                                      rsp.mount_attempt, want.mount_attempt));
          if (rsp.unmount_request !== want.unmount_request)
            report_mismatch($sformatf("unmount_request %b, expected %b",
                                      rsp.unmount_request, want.unmount_request));
          if (rsp.state_changed !== want.state_changed)
            report_mismatch($sformatf("state_changed %b, expected %b",
                                      rsp.state_changed, want.state_changed));
          if (rsp.error_code !== want.error_code)
            report_mismatch($sformatf("error_code %0d, expected %0d",
                                      rsp.error_code, want.error_code));
        end
      end
      if (req_valid && req_ready) status_q.push_back(mount_fsm_step(req));
    end
    pending = status_q.size();
  end

endmodule

/* tb/card_detect_mount_fsm_tb.sv */
`timescale 1ns / 1ps

module card_detect_mount_fsm_tb;
  import cdm_pkg::*;

  // Generous ceiling: far above the slowest legal run with every gap and stall
  localparam int unsigned RUN_LIMIT_NS = 20_000_000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_ready;
  cdm_req_t             req = '0;
  logic                 rsp_valid;
  logic                 rsp_ready = 1'b0;
  cdm_rsp_t             rsp;
  logic                 cfg_we = 1'b0;
  logic [CDM_CFG_W-1:0] cfg_data = '0;

  int fail_count;
  int pending;
  int results_seen;
  int attempts_seen;
  int unmounts_seen;

  // Stimulus bookkeeping
  int unsigned          reqs_sent = 0;
  int unsigned          settings_used = 1;
  logic [CDM_CFG_W-1:0] deb_now = CDM_DEBOUNCE_RESET;
  logic                 quiet = 1'b0;
  int                   rsp_hold = 0;

  card_detect_mount_fsm u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  card_detect_mount_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .req           (req),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .rsp           (rsp),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .results_seen  (results_seen),
    .attempts_seen (attempts_seen),
    .unmounts_seen (unmounts_seen)
  );

  // 12 ns period clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 0;
  end

  // Idle length: mostly short, now and then long
  function automatic int idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  // Result side: drop ready for random stretches, hold it high when quiet
  always @(posedge clk) begin
    if (rsp_hold != 0) begin
      rsp_hold  <= rsp_hold - 1;
      rsp_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 99) < 20) begin
      rsp_hold  <= idle_len() - 1;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  // Present one request and hold it until the block takes it. Returns at the
  // accepting edge, so a back-to-back request keeps valid high without a dip.
  task automatic send_req(input logic present, input logic tick, input logic ok);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 99) < 35) gap = idle_len();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= cdm_req_t'({present, tick, ok});
    do @(posedge clk); while (!req_ready);
    reqs_sent++;
  endtask

  // Drop valid and wait until every expected status has come back; realign
  // to a rising edge before returning.
  task automatic drain_results();
    req_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // Reconfigure only with the block idle
  task automatic write_debounce(input logic [CDM_CFG_W-1:0] value);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we  <= 1'b0;
    deb_now = value;
    settings_used++;
  endtask

  // Mostly well-formed remove/insert episodes with random content, some of
  // them cut short, plus bursts of raw noise
  task automatic run_random(input int unsigned n_items);
    int unsigned target;
    int unsigned kind;
    int unsigned run_len;
    int unsigned need;
    target = reqs_sent + n_items;
    need   = (deb_now == 0) ? 1 : deb_now;
    while (reqs_sent < target) begin
      quiet = ($urandom_range(0, 7) == 0);
      kind  = $urandom_range(0, 9);
      if (kind < 2) begin
        run_len = $urandom_range(1, 6);
        repeat (run_len) send_req(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)));
      end else begin
        // Remove the card for a few samples
        run_len = $urandom_range(1, 4);
        repeat (run_len) send_req(1'b0, 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)));
        // Insert it: long enough to mount, or pull it early
        if (kind < 4) begin
          run_len = $urandom_range(1, (need < 4) ? 2 : need);
          if (run_len > 60) run_len = $urandom_range(1, 60);
        end else begin
          run_len = 2 * need + $urandom_range(1, 6);
          if (run_len > 60) run_len = $urandom_range(40, 60);
        end
        repeat (run_len) send_req(1'b1, $urandom_range(0, 3) != 0,
                                  1'($urandom_range(0, 1)));
      end
      // Hold off the sender now and then until the results are all back
      if ($urandom_range(0, 24) == 0) drain_results();
    end
    quiet = 1'b0;
  endtask

  initial begin
    int unsigned ticks;
    logic        t;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset value of debounce_ms: first mount from start fails
    send_req(1'b1, 1'b0, 1'b0);
    send_req(1'b1, 1'b1, 1'b1);   // mount failed, card still in: stay
    send_req(1'b0, 1'b1, 1'b1);   // removal from mount failed
    send_req(1'b0, 1'b1, 1'b0);   // unmounted, still absent
    send_req(1'b1, 1'b1, 1'b1);   // insert: arm, this tick ignored
    send_req(1'b0, 1'b0, 1'b1);   // pulled during debounce: disarm
    send_req(1'b1, 1'b0, 1'b0);   // insert again
    // Keep the card in through the full reset-value debounce
    ticks = 0;
    while (ticks < CDM_DEBOUNCE_RESET) begin
      t = ($urandom_range(0, 6) != 0);
      if (t) ticks++;
      send_req(1'b1, t,
               (ticks == CDM_DEBOUNCE_RESET) ? 1'b1 : 1'($urandom_range(0, 1)));
    end
    send_req(1'b1, 1'b1, 1'b0);   // mounted, card present: stay
    send_req(1'b0, 1'b0, 1'b1);   // removal while mounted: unmount

    // Shortest debounce
    write_debounce(16'd1);
    send_req(1'b1, 1'b1, 1'b1);   // arm on a tick
    send_req(1'b1, 1'b1, 1'b0);   // first later tick: mount fails
    send_req(1'b0, 1'b0, 1'b0);
    send_req(1'b1, 1'b0, 1'b1);
    send_req(1'b1, 1'b0, 1'b0);   // no tick: keep waiting
    send_req(1'b1, 1'b1, 1'b1);   // mount succeeds, error cleared
    send_req(1'b1, 1'b1, 1'b0);
    send_req(1'b0, 1'b1, 1'b1);

    // Zero debounce fires on the next tick
    write_debounce(16'd0);
    send_req(1'b1, 1'b0, 1'b0);
    send_req(1'b1, 1'b1, 1'b1);
    send_req(1'b0, 1'b0, 1'b0);
    run_random(150);

    // Walk through the extremes and a spread of small settings
    write_debounce(16'd1);
    run_random(150);
    write_debounce(16'hFFFF);
    run_random(150);
    write_debounce(16'd2);
    run_random(150);
    write_debounce(16'd3);
    run_random(150);
    repeat (4) begin
      write_debounce(CDM_CFG_W'($urandom_range(1, 12)));
      run_random(150);
    end
    write_debounce(CDM_CFG_W'($urandom_range(0, 16'hFFFF)));
    run_random(40);

    // Let everything come back before reporting
    drain_results();
    repeat (4) @(posedge clk);

    $display("Sent %0d requests over %0d debounce settings, checked %0d results,",
             reqs_sent, settings_used, results_seen);
    $display("seeing %0d mount attempts and %0d unmount requests.",
             attempts_seen, unmounts_seen);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(RUN_LIMIT_NS);
    $display("Timed out with %0d results outstanding", pending);
    $display("Verification failed");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/cdm_pkg.sv
rtl/cdm_core.sv
rtl/card_detect_mount_fsm.sv
rtl/cdm_checker.sv
tb/card_detect_mount_checker.sv
tb/card_detect_mount_fsm_tb.sv
